@@ design/skle_pkg.sv @@
// Shared types, constants and the key character table for the stick
// keyboard line editor. No dependencies.

package skle_pkg;

    typedef enum logic [2:0] {
        OP_KEY   = 3'd0,
        OP_BYTE  = 3'd1,
        OP_BKSP  = 3'd2,
        OP_LEFT  = 3'd3,
        OP_RIGHT = 3'd4,
        OP_ARM   = 3'd5,
        OP_READ  = 3'd6
    } op_t;

    localparam logic [7:0] CUT_LOW        = 8'd85;
    localparam logic [7:0] CUT_HIGH       = 8'd170;
    localparam logic [7:0] BACKSPACE_CODE = 8'h08;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_MARK      = 8'h80;
    localparam logic [8:0] CAP_RESET      = 9'd256;

    // [page][cell][face], page = {key_mode, shift_on}
    localparam logic [7:0] KEY_ROM [0:3][0:8][0:3] = '{
        '{ '{8'h2C, 8'h61, 8'h62, 8'h63}, '{8'h2E, 8'h64, 8'h65, 8'h66},
           '{8'h21, 8'h67, 8'h68, 8'h69}, '{8'h2D, 8'h6A, 8'h6B, 8'h6C},
           '{8'h08, 8'h6D, 8'h20, 8'h6E}, '{8'h3F, 8'h6F, 8'h70, 8'h71},
           '{8'h28, 8'h72, 8'h73, 8'h74}, '{8'h3A, 8'h75, 8'h76, 8'h77},
           '{8'h29, 8'h78, 8'h79, 8'h7A} },
        '{ '{8'h5E, 8'h41, 8'h42, 8'h43}, '{8'h40, 8'h44, 8'h45, 8'h46},
           '{8'h2A, 8'h47, 8'h48, 8'h49}, '{8'h5F, 8'h4A, 8'h4B, 8'h4C},
           '{8'h08, 8'h4D, 8'h20, 8'h4E}, '{8'h22, 8'h4F, 8'h50, 8'h51},
           '{8'h3D, 8'h52, 8'h53, 8'h54}, '{8'h3B, 8'h55, 8'h56, 8'h57},
           '{8'h2F, 8'h58, 8'h59, 8'h5A} },
        '{ '{8'h00, 8'h00, 8'h00, 8'h31}, '{8'h00, 8'h00, 8'h00, 8'h32},
           '{8'h00, 8'h00, 8'h00, 8'h33}, '{8'h00, 8'h00, 8'h00, 8'h34},
           '{8'h08, 8'h00, 8'h20, 8'h35}, '{8'h00, 8'h00, 8'h00, 8'h36},
           '{8'h00, 8'h00, 8'h00, 8'h37}, '{8'h00, 8'h00, 8'h00, 8'h38},
           '{8'h00, 8'h00, 8'h30, 8'h39} },
        '{ '{8'h2C, 8'h28, 8'h2E, 8'h29}, '{8'h22, 8'h3C, 8'h27, 8'h3E},
           '{8'h2D, 8'h5B, 8'h5F, 8'h5D}, '{8'h21, 8'h7B, 8'h3F, 8'h7D},
           '{8'h08, 8'h00, 8'h20, 8'h00}, '{8'h2B, 8'h5C, 8'h3D, 8'h2F},
           '{8'h3A, 8'h40, 8'h3B, 8'h23}, '{8'h7E, 8'h24, 8'h60, 8'h25},
           '{8'h2A, 8'h5E, 8'h7C, 8'h26} }
    };

    function automatic logic [1:0] axis_cut(input logic [7:0] v);
        logic [1:0] r;
        if (v < CUT_LOW) begin
            r = 2'd0;
        end else if (v > CUT_HIGH) begin
            r = 2'd2;
        end else begin
            r = 2'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] key_lookup(
        input logic       mode,
        input logic       shift,
        input logic [1:0] face,
        input logic [7:0] sx,
        input logic [7:0] sy
    );
        logic [3:0] cell_idx;
        cell_idx = 4'(axis_cut(sy)) * 4'd3 + 4'(axis_cut(sx));
        return KEY_ROM[{mode, shift}][cell_idx][face];
    endfunction

endpackage

@@ design/skle_text_ram.sv @@
// Text byte store: one write port, one read port, registered read data.
// No dependencies.

module skle_text_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/stick_keyboard_line_editor.sv @@
// Stick keyboard line editor top level: sequencer, edit state, output register.
// Depends on skle_pkg and skle_text_ram.
//
// Processing: arm, rejected ops and moves at an end go straight to the
// result; read takes one text store read. Insert shifts the bytes from the
// cursor to the end up one place, one byte moved per cycle, then writes the
// new byte. Move scans over continuation bytes. Backspace scans back to the
// start of the character, then moves the following bytes down. One transaction
// at a time; the next can be taken from the cycle the result appears. Reset:
// length, cursor, replace-all cleared, capacity 256; store contents undefined
// until written.

module stick_keyboard_line_editor #(
    parameter int BUFFER_SIZE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] op,
    input  logic [7:0] stick_x,
    input  logic [7:0] stick_y,
    input  logic [1:0] face_button,
    input  logic       key_mode,
    input  logic       shift_on,
    input  logic [7:0] byte_value,
    input  logic [7:0] read_index,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       changed,
    output logic [7:0] key_char,
    output logic [7:0] cursor_now,
    output logic [7:0] length_now,
    output logic       replace_now,
    output logic [7:0] read_data,
    // capacity register
    input  logic       cfg_wr_en,
    input  logic [8:0] cfg_wr_data
);

    localparam int AW   = $clog2(BUFFER_SIZE);
    localparam int CAPW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int WW   = (AW > 8) ? AW : 8;
    localparam logic [CAPW-1:0] BUF_CAP = CAPW'(BUFFER_SIZE);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN_L,
        S_SCAN_R,
        S_SHUP,
        S_SHDN,
        S_PUT,
        S_READ,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      len_reg, len_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic               repl_reg, repl_next;
    logic [8:0]         cap_reg, cap_next;
    skle_pkg::op_t      op_reg, op_next;
    logic [7:0]         ch_reg, ch_next;
    logic [7:0]         kc_reg, kc_next;
    logic [7:0]         ridx_reg, ridx_next;
    logic [AW-1:0]      ptr_reg, ptr_next;   // scan position / shift source
    logic [AW-1:0]      wa_reg, wa_next;     // shift write address
    logic               pend_reg, pend_next; // read in flight, write due
    logic               chg_reg, chg_next;
    logic [7:0]         rd_reg, rd_next;

    logic               out_valid_reg, out_valid_next;
    logic               changed_reg, changed_next;
    logic [7:0]         key_char_reg, key_char_next;
    logic [7:0]         cursor_now_reg, cursor_now_next;
    logic [7:0]         length_now_reg, length_now_next;
    logic               replace_now_reg, replace_now_next;
    logic [7:0]         read_data_reg, read_data_next;

    // text store port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    // shared pointer stepper: down for left scans and upward shifts
    logic               step_down;
    logic [AW-1:0]      ptr_step;

    logic               accept;
    logic               is_cont;
    logic               cur_gt_len;
    logic [CAPW-1:0]    cap_ext, cap_eff, len_ext, ins_len_ext;
    logic [AW-1:0]      ins_len;
    logic [AW-1:0]      cur_dec, cur_inc, len_inc, wa_inc;
    logic [WW-1:0]      ridx_w, cur_w, len_w;
    logic               ridx_hit;
    logic               out_free;

    skle_text_ram #(
        .DEPTH (BUFFER_SIZE),
        .AW    (AW)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign step_down = (state_reg == S_SCAN_L) || (state_reg == S_SHUP);
    assign ptr_step  = ptr_reg + (step_down ? {AW{1'b1}} : AW'(1));

    // UTF-8 continuation byte is 10xxxxxx
    assign is_cont    = (ram_rdata & skle_pkg::CONT_MASK) == skle_pkg::CONT_MARK;
    assign cur_gt_len = cur_reg > len_reg;

    // capacity above the buffer size acts as the buffer size
    assign cap_ext     = CAPW'(cap_reg);
    assign cap_eff     = (cap_ext > BUF_CAP) ? BUF_CAP : cap_ext;
    assign len_ext     = CAPW'(len_reg);
    assign ins_len     = repl_reg ? '0 : len_reg;
    assign ins_len_ext = CAPW'(ins_len);

    assign cur_dec = cur_reg - AW'(1);
    assign cur_inc = cur_reg + AW'(1);
    assign len_inc = len_reg + AW'(1);
    assign wa_inc  = wa_reg + AW'(1);

    assign ridx_w   = WW'(ridx_reg);
    assign ridx_hit = ridx_w < WW'(len_reg);
    assign cur_w    = WW'(cur_reg);
    assign len_w    = WW'(len_reg);

    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        cur_next         = cur_reg;
        repl_next        = repl_reg;
        cap_next         = cfg_wr_en ? cfg_wr_data : cap_reg;
        op_next          = op_reg;
        ch_next          = ch_reg;
        kc_next          = kc_reg;
        ridx_next        = ridx_reg;
        ptr_next         = ptr_reg;
        wa_next          = wa_reg;
        pend_next        = pend_reg;
        chg_next         = chg_reg;
        rd_next          = rd_reg;
        out_valid_next   = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        changed_next     = changed_reg;
        key_char_next    = key_char_reg;
        cursor_now_next  = cursor_now_reg;
        length_now_next  = length_now_reg;
        replace_now_next = replace_now_reg;
        read_data_next   = read_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = wa_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = ptr_step;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = skle_pkg::op_t'(op);
                    kc_next   = skle_pkg::key_lookup(key_mode, shift_on, face_button,
                                                     stick_x, stick_y);
                    ch_next   = (skle_pkg::op_t'(op) == skle_pkg::OP_KEY) ? kc_next
                                                                            : byte_value;
                    ridx_next = read_index;
                    chg_next  = 1'b0;
                    rd_next   = 8'd0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_FINISH;
                case (op_reg)
                    skle_pkg::OP_KEY, skle_pkg::OP_BYTE:
                    begin
                        // zero, the backspace code, no room or a stray cursor: nothing
                        if (!(cap_eff == '0 || ch_reg == 8'd0 ||
                              ch_reg == skle_pkg::BACKSPACE_CODE ||
                              len_ext >= cap_eff || cur_gt_len))
                        begin
                            if (repl_reg)
                            begin
                                len_next  = '0;
                                cur_next  = '0;
                                repl_next = 1'b0;
                            end
                            // replace-all still happens when only room fails
                            if (ins_len_ext + CAPW'(1) < cap_eff)
                            begin
                                chg_next   = 1'b1;
                                ptr_next   = ins_len;
                                pend_next  = 1'b0;
                                state_next = S_SHUP;
                            end
                        end
                    end

                    skle_pkg::OP_BKSP:
                    begin
                        if (!cur_gt_len)
                        begin
                            if (repl_reg)
                            begin
                                chg_next  = (len_reg != '0);
                                len_next  = '0;
                                cur_next  = '0;
                                repl_next = 1'b0;
                            end
                            else if (cur_reg != '0)
                            begin
                                ram_raddr  = cur_dec;
                                ptr_next   = cur_dec;
                                state_next = S_SCAN_L;
                            end
                        end
                    end

                    skle_pkg::OP_LEFT:
                    begin
                        if (!cur_gt_len)
                        begin
                            chg_next  = repl_reg;
                            repl_next = 1'b0;
                            if (cur_reg != '0)
                            begin
                                ram_raddr  = cur_dec;
                                ptr_next   = cur_dec;
                                state_next = S_SCAN_L;
                            end
                        end
                    end

                    skle_pkg::OP_RIGHT:
                    begin
                        if (!cur_gt_len)
                        begin
                            chg_next  = repl_reg;
                            repl_next = 1'b0;
                            if (cur_reg != len_reg)
                            begin
                                ram_raddr  = cur_inc;
                                ptr_next   = cur_inc;
                                state_next = S_SCAN_R;
                            end
                        end
                    end

                    skle_pkg::OP_ARM:
                    begin
                        chg_next  = !repl_reg;
                        repl_next = 1'b1;
                    end

                    skle_pkg::OP_READ:
                    begin
                        ram_raddr  = ridx_w[AW-1:0];
                        state_next = S_READ;
                    end

                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_SCAN_L:
            begin
                // ram_rdata holds the byte at ptr_reg; the next one down is in flight
                if (ptr_reg == '0 || !is_cont)
                begin
                    chg_next = 1'b1;
                    cur_next = ptr_reg;
                    if (op_reg == skle_pkg::OP_BKSP)
                    begin
                        wa_next    = ptr_reg;
                        ptr_next   = cur_reg;
                        pend_next  = 1'b0;
                        state_next = S_SHDN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    ptr_next = ptr_step;
                end
            end

            S_SCAN_R:
            begin
                if (ptr_reg == len_reg || !is_cont)
                begin
                    chg_next   = 1'b1;
                    cur_next   = ptr_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next = ptr_step;
                end
            end

            S_SHUP:
            begin
                // byte read last cycle lands one place higher
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (ptr_reg > cur_reg)
                begin
                    wa_next   = ptr_reg;
                    ptr_next  = ptr_step;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_reg;
                ram_wdata  = ch_reg;
                cur_next   = cur_inc;
                len_next   = len_inc;
                state_next = S_FINISH;
            end

            S_SHDN:
            begin
                // close the gap: source ptr_reg, destination wa_reg
                if (pend_reg)
                begin
                    ram_we  = 1'b1;
                    wa_next = wa_inc;
                end
                if (ptr_reg < len_reg)
                begin
                    ram_raddr = ptr_reg;
                    ptr_next  = ptr_step;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        len_next   = wa_reg;
                        state_next = S_FINISH;
                    end
                end
            end

            S_READ:
            begin
                rd_next    = ridx_hit ? ram_rdata : 8'd0;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    changed_next     = chg_reg;
                    key_char_next    = (op_reg == skle_pkg::OP_KEY) ? kc_reg : 8'd0;
                    cursor_now_next  = cur_w[7:0];
                    length_now_next  = len_w[7:0];
                    replace_now_next = repl_reg;
                    read_data_next   = rd_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            cur_reg         <= '0;
            repl_reg        <= 1'b0;
            cap_reg         <= skle_pkg::CAP_RESET;
            op_reg          <= skle_pkg::OP_KEY;
            ch_reg          <= 8'd0;
            kc_reg          <= 8'd0;
            ridx_reg        <= 8'd0;
            ptr_reg         <= '0;
            wa_reg          <= '0;
            pend_reg        <= 1'b0;
            chg_reg         <= 1'b0;
            rd_reg          <= 8'd0;
            out_valid_reg   <= 1'b0;
            changed_reg     <= 1'b0;
            key_char_reg    <= 8'd0;
            cursor_now_reg  <= 8'd0;
            length_now_reg  <= 8'd0;
            replace_now_reg <= 1'b0;
            read_data_reg   <= 8'd0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            cur_reg         <= cur_next;
            repl_reg        <= repl_next;
            cap_reg         <= cap_next;
            op_reg          <= op_next;
            ch_reg          <= ch_next;
            kc_reg          <= kc_next;
            ridx_reg        <= ridx_next;
            ptr_reg         <= ptr_next;
            wa_reg          <= wa_next;
            pend_reg        <= pend_next;
            chg_reg         <= chg_next;
            rd_reg          <= rd_next;
            out_valid_reg   <= out_valid_next;
            changed_reg     <= changed_next;
            key_char_reg    <= key_char_next;
            cursor_now_reg  <= cursor_now_next;
            length_now_reg  <= length_now_next;
            replace_now_reg <= replace_now_next;
            read_data_reg   <= read_data_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign changed     = changed_reg;
    assign key_char    = key_char_reg;
    assign cursor_now  = cursor_now_reg;
    assign length_now  = length_now_reg;
    assign replace_now = replace_now_reg;
    assign read_data   = read_data_reg;

    // cursor never sits past the text between transactions
    a_cur_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cur_reg <= len_reg))
        else $error("cursor beyond text length while idle");

    // an accepted transaction always goes to the decision step
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DECIDE))
        else $error("accepted transaction did not reach decision step");

    // a result appears only from the finishing step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finishing step");

    // upward shift never reads below the cursor
    a_shup_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHUP) |-> (ptr_reg >= cur_reg))
        else $error("upward shift source below cursor");

    // downward shift never reads past the text
    a_shdn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHDN) |-> (ptr_reg <= len_reg && wa_reg <= ptr_reg))
        else $error("downward shift pointers out of order");

endmodule
